// ----- src/bqf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqf_pkg
// Shared types and constants of the biquad low/high-pass filter: filter modes,
// configuration register indexes and coefficient format.
// ----------------------------------------------------------------------------
package bqf_pkg;

  // coefficient format, signed q3.15 words
  localparam int COEF_WIDTH = 18;

  // configuration port geometry
  localparam int CFG_ADDR_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = COEF_WIDTH;

  // filter mode codes, the unused code behaves as bypass
  typedef enum logic [1:0] {
    MODE_LOW_PASS  = 2'd0,
    MODE_HIGH_PASS = 2'd1,
    MODE_BYPASS    = 2'd2
  } bqf_mode_e;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_WIDTH-1:0] {
    REG_FILTER_MODE   = 3'd0,
    REG_GAIN_INPUT    = 3'd1,
    REG_GAIN_PREV_IN1 = 3'd2,
    REG_GAIN_PREV_IN2 = 3'd3,
    REG_FEEDBACK_ONE  = 3'd4,
    REG_FEEDBACK_TWO  = 3'd5
  } bqf_reg_e;

  typedef logic signed [COEF_WIDTH-1:0] bqf_coef_t;

endpackage
`default_nettype wire

// ----- src/bqf_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bqf_if
// Valid/ready stream interfaces of the biquad filter: the sample input channel
// and the filtered result channel.
// ----------------------------------------------------------------------------

// input sample channel
interface bqf_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;
  logic                           first_of_stream;

  modport source (output valid, output sample_in, output first_of_stream, input ready);
  modport sink   (input valid, input sample_in, input first_of_stream, output ready);
endinterface

// result channel
interface bqf_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface
`default_nettype wire

// ----- src/biquad_low_high_pass_filter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// biquad_low_high_pass_filter
// Second-order direct-form-1 iir filter with low-pass, high-pass and bypass
// modes on a stream of signed samples.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one sample beat per item, out_o one result beat per item.
//   Coefficients (signed q3.15) and the mode are written through the plain
//   write port cfg_we_i / cfg_addr_i / cfg_data_i while the stream is idle;
//   indexes above the register list are ignored.
//   An accepted beat lands in an input register; an edge on which the
//   result register can advance computes the five products, the sum, the
//   shift and the saturation in one pass and loads the result register
//   and the history together. Throughput is one sample per cycle while
//   the receiver keeps taking results: the history update is registered
//   with the result, so the next beat in the input register sees it.
//   When the receiver stalls, the result register holds its beat and the
//   input register keeps one more; in_i.ready drops only when both are full.
//   Reset clears the mode, all coefficients, the history and both valid
//   flags. A beat with first_of_stream set clears the history before use,
//   in bypass mode too.
// ----------------------------------------------------------------------------
module biquad_low_high_pass_filter #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 15
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [bqf_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr_i,
  input  wire logic [bqf_pkg::CFG_DATA_WIDTH-1:0] cfg_data_i,
  bqf_in_if.sink                                  in_i,
  bqf_out_if.source                               out_o
);
  import bqf_pkg::*;

  localparam int PROD_WIDTH = COEF_WIDTH + SAMPLE_WIDTH;
  localparam int ACC_WIDTH  = PROD_WIDTH + 3;

  // configuration registers
  logic [1:0] filter_mode_q;
  bqf_coef_t  gain_input_q, gain_prev_in1_q, gain_prev_in2_q;
  bqf_coef_t  feedback_one_q, feedback_two_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_mode_q   <= MODE_LOW_PASS;
      gain_input_q    <= '0;
      gain_prev_in1_q <= '0;
      gain_prev_in2_q <= '0;
      feedback_one_q  <= '0;
      feedback_two_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_FILTER_MODE:   filter_mode_q   <= cfg_data_i[1:0];
        REG_GAIN_INPUT:    gain_input_q    <= bqf_coef_t'(cfg_data_i);
        REG_GAIN_PREV_IN1: gain_prev_in1_q <= bqf_coef_t'(cfg_data_i);
        REG_GAIN_PREV_IN2: gain_prev_in2_q <= bqf_coef_t'(cfg_data_i);
        REG_FEEDBACK_ONE:  feedback_one_q  <= bqf_coef_t'(cfg_data_i);
        REG_FEEDBACK_TWO:  feedback_two_q  <= bqf_coef_t'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // handshake control
  logic in_valid_q, out_valid_q;
  logic advance, compute;

  assign advance    = !out_valid_q || out_o.ready;
  assign compute    = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) in_valid_q <= in_i.valid;
      if (advance)    out_valid_q <= in_valid_q;
    end
  end

  // input register
  logic signed [SAMPLE_WIDTH-1:0] sample_q;
  logic                           first_q;

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      sample_q <= in_i.sample_in;
      first_q  <= in_i.first_of_stream;
    end
  end

  // history, cleared at start of stream before use
  logic signed [SAMPLE_WIDTH-1:0] x1_q, x2_q, y1_q, y2_q;
  logic signed [SAMPLE_WIDTH-1:0] x1, x2, y1, y2;

  assign x1 = first_q ? '0 : x1_q;
  assign x2 = first_q ? '0 : x2_q;
  assign y1 = first_q ? '0 : y1_q;
  assign y2 = first_q ? '0 : y2_q;

  // five products and full width sum
  logic signed [PROD_WIDTH-1:0] p_in, p_x1, p_x2, p_y1, p_y2;
  logic signed [ACC_WIDTH-1:0]  acc, acc_shift;

  assign p_in = gain_input_q    * sample_q;
  assign p_x1 = gain_prev_in1_q * x1;
  assign p_x2 = gain_prev_in2_q * x2;
  assign p_y1 = feedback_one_q  * y1;
  assign p_y2 = feedback_two_q  * y2;

  assign acc = ACC_WIDTH'(p_in) + ACC_WIDTH'(p_x1) + ACC_WIDTH'(p_x2)
             - ACC_WIDTH'(p_y1) - ACC_WIDTH'(p_y2);
  assign acc_shift = acc >>> COEF_FRAC_BITS;

  // saturation of the low-pass value
  localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic                           lp_fits;
  logic signed [SAMPLE_WIDTH-1:0] lp;

  assign lp_fits = (&acc_shift[ACC_WIDTH-1:SAMPLE_WIDTH-1])
                || !(|acc_shift[ACC_WIDTH-1:SAMPLE_WIDTH-1]);
  assign lp = lp_fits ? acc_shift[SAMPLE_WIDTH-1:0]
                      : (acc_shift[ACC_WIDTH-1] ? SAT_MIN : SAT_MAX);

  // high-pass difference and its saturation
  logic signed [SAMPLE_WIDTH:0]   diff;
  logic                           hp_fits;
  logic signed [SAMPLE_WIDTH-1:0] hp;

  assign diff    = (SAMPLE_WIDTH+1)'(sample_q) - (SAMPLE_WIDTH+1)'(lp);
  assign hp_fits = diff[SAMPLE_WIDTH] == diff[SAMPLE_WIDTH-1];
  assign hp      = hp_fits ? diff[SAMPLE_WIDTH-1:0]
                           : (diff[SAMPLE_WIDTH] ? SAT_MIN : SAT_MAX);

  // result selection by mode
  logic                           filtering;
  logic signed [SAMPLE_WIDTH-1:0] result_d;
  logic                           clipped_d;

  assign filtering = (filter_mode_q == MODE_LOW_PASS) || (filter_mode_q == MODE_HIGH_PASS);

  always_comb begin
    case (filter_mode_q)
      MODE_LOW_PASS: begin
        result_d  = lp;
        clipped_d = !lp_fits;
      end
      MODE_HIGH_PASS: begin
        result_d  = hp;
        clipped_d = !lp_fits || !hp_fits;
      end
      default: begin
        result_d  = sample_q;
        clipped_d = 1'b0;
      end
    endcase
  end

  // history update, bypass keeps it but still honors start of stream
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= '0;
      x2_q <= '0;
      y1_q <= '0;
      y2_q <= '0;
    end else if (compute) begin
      if (filtering) begin
        x2_q <= x1;
        x1_q <= sample_q;
        y2_q <= y1;
        y1_q <= lp;
      end else begin
        x1_q <= x1;
        x2_q <= x2;
        y1_q <= y1;
        y2_q <= y2;
      end
    end
  end

  // result register
  logic signed [SAMPLE_WIDTH-1:0] result_q;
  logic                           clipped_q;

  always_ff @(posedge clk_i) begin
    if (compute) begin
      result_q  <= result_d;
      clipped_q <= clipped_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = result_q;
  assign out_o.clipped    = clipped_q;

endmodule
`default_nettype wire

// ----- sim/tb_biquad_low_high_pass_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_biquad_low_high_pass_filter
// Self-checking bench for the biquad filter. A bit-exact fixed-point model
// of the filter predicts every result beat. Directed tests cover reset
// defaults, unity gain, saturation, high-pass, bypass, the unused mode and
// unused register indexes. Random filter streams follow, with varied
// coefficients and random gaps on both the sample and the result channel.
// ----------------------------------------------------------------------------
module tb_biquad_low_high_pass_filter;
  import bqf_pkg::*;

  localparam int SAMPLE_W    = 16;
  localparam int COEF_FRAC   = 15;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYC  = 4;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_SPARE_SIX   = 3'd6;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_SPARE_SEVEN = 3'd7;

  localparam logic signed [63:0] SAMPLE_MAX = 64'sd32767;
  localparam logic signed [63:0] SAMPLE_MIN = -64'sd32768;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_TOP = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_BOT = 16'sh8000;

  localparam bqf_coef_t COEF_TOP  = 18'sh1ffff;
  localparam bqf_coef_t COEF_BOT  = 18'sh20000;
  localparam bqf_coef_t COEF_ONE  = 18'sh08000;
  localparam bqf_coef_t COEF_HALF = 18'sh04000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       clipped;
  } filt_result_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CFG_ADDR_WIDTH-1:0] cfg_addr_i;
  logic [CFG_DATA_WIDTH-1:0] cfg_data_i;

  bqf_in_if  #(.SAMPLE_WIDTH(SAMPLE_W)) in_bus ();
  bqf_out_if #(.SAMPLE_WIDTH(SAMPLE_W)) out_bus ();

  biquad_low_high_pass_filter #(
    .SAMPLE_WIDTH  (SAMPLE_W),
    .COEF_FRAC_BITS(COEF_FRAC)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_addr_i(cfg_addr_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_bus),
    .out_o     (out_bus)
  );

  // model copy of configuration and history
  logic [1:0]                 filt_mode;
  bqf_coef_t                  coef_in, coef_x1, coef_x2, coef_y1, coef_y2;
  logic signed [SAMPLE_W-1:0] hist_x1, hist_x2, hist_y1, hist_y2;

  filt_result_t expected_results[$];
  int           err_count;
  int           cycle_count;
  bit           idle_en;

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // saturate to the sample width
  function automatic logic signed [SAMPLE_W-1:0] clamp_sample(
      input logic signed [63:0] v, inout logic hit);
    if (v > SAMPLE_MAX) begin
      hit = 1'b1;
      return SAMPLE_TOP;
    end
    if (v < SAMPLE_MIN) begin
      hit = 1'b1;
      return SAMPLE_BOT;
    end
    return v[SAMPLE_W-1:0];
  endfunction

  // filter one sample, update the history
  function automatic filt_result_t filter_sample(
      input logic signed [SAMPLE_W-1:0] s, input logic first);
    logic signed [63:0]         acc;
    logic signed [63:0]         diff;
    logic signed [SAMPLE_W-1:0] lp;
    logic                       hit;
    filt_result_t               r;
    hit = 1'b0;
    if (first) begin
      hist_x1 = '0;
      hist_x2 = '0;
      hist_y1 = '0;
      hist_y2 = '0;
    end
    if (filt_mode == MODE_LOW_PASS || filt_mode == MODE_HIGH_PASS) begin
      acc = coef_in * s + coef_x1 * hist_x1 + coef_x2 * hist_x2
            - coef_y1 * hist_y1 - coef_y2 * hist_y2;
      lp = clamp_sample(acc >>> COEF_FRAC, hit);
      hist_x2 = hist_x1;
      hist_x1 = s;
      hist_y2 = hist_y1;
      hist_y1 = lp;
      if (filt_mode == MODE_LOW_PASS) begin
        r.sample_out = lp;
      end else begin
        diff = s;
        diff = diff - lp;
        r.sample_out = clamp_sample(diff, hit);
      end
    end else begin
      r.sample_out = s;
    end
    r.clipped = hit;
    return r;
  endfunction

  // result beat checker
  always @(posedge clk_i) begin
    filt_result_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no sample pending: sample_out %0d clipped %0b",
               out_bus.sample_out, out_bus.clipped);
        err_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_bus.sample_out !== want.sample_out) begin
          $error("sample_out: expected %0d, actual %0d", want.sample_out,
                 out_bus.sample_out);
          err_count++;
        end
        if (out_bus.clipped !== want.clipped) begin
          $error("clipped: expected %0b, actual %0b", want.clipped, out_bus.clipped);
          err_count++;
        end
      end
    end
  end

  // result channel back-pressure
  initial begin
    int stall;
    out_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = idle_en ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!out_bus.valid);
    end
  end

  // send one sample beat and record its expected result
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic first);
    int gap;
    gap = idle_en ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid           <= 1'b1;
    in_bus.sample_in       <= s;
    in_bus.first_of_stream <= first;
    do @(posedge clk_i); while (!in_bus.ready);
    expected_results.push_back(filter_sample(s, first));
  endtask

  // stop sending and let every pending result come out
  task automatic drain_stream();
    in_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // one register write, write enable left high
  task automatic write_reg(input logic [CFG_ADDR_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_FILTER_MODE:   filt_mode = data[1:0];
      REG_GAIN_INPUT:    coef_in   = data;
      REG_GAIN_PREV_IN1: coef_x1   = data;
      REG_GAIN_PREV_IN2: coef_x2   = data;
      REG_FEEDBACK_ONE:  coef_y1   = data;
      REG_FEEDBACK_TWO:  coef_y2   = data;
      default: ;
    endcase
  endtask

  // load mode and all coefficients while the stream is idle
  task automatic program_filter(input logic [1:0] mode, input bqf_coef_t g0,
                                input bqf_coef_t g1, input bqf_coef_t g2,
                                input bqf_coef_t f1, input bqf_coef_t f2);
    drain_stream();
    // upper bits of the mode word carry junk
    write_reg(REG_FILTER_MODE, {16'($urandom), mode});
    write_reg(REG_GAIN_INPUT, g0);
    write_reg(REG_GAIN_PREV_IN1, g1);
    write_reg(REG_GAIN_PREV_IN2, g2);
    write_reg(REG_FEEDBACK_ONE, f1);
    write_reg(REG_FEEDBACK_TWO, f2);
    cfg_we_i <= 1'b0;
  endtask

  function automatic bqf_coef_t pick_coef();
    case ($urandom_range(0, 7))
      0:       return COEF_TOP;
      1:       return COEF_BOT;
      2:       return '0;
      3, 4:    return 18'($urandom_range(0, 65535)) - 18'sd32768;
      default: return 18'($urandom);
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_TOP;
      1:       return SAMPLE_BOT;
      2, 3:    return 16'($urandom_range(0, 511)) - 16'sd256;
      default: return 16'($urandom);
    endcase
  endfunction

  // registers at reset: low-pass with zero gains
  task automatic test_reset_defaults();
    send_sample(SAMPLE_TOP, 1'b0);
    send_sample(SAMPLE_BOT, 1'b1);
  endtask

  // unity gain, then saturation both ways
  task automatic test_low_pass_gain();
    program_filter(MODE_LOW_PASS, COEF_ONE, '0, '0, '0, '0);
    send_sample(SAMPLE_TOP, 1'b1);
    send_sample(SAMPLE_BOT, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd1, 1'b0);
    program_filter(MODE_LOW_PASS, COEF_TOP, COEF_TOP, COEF_TOP, COEF_BOT, COEF_BOT);
    send_sample(SAMPLE_TOP, 1'b1);
    send_sample(SAMPLE_TOP, 1'b0);
    send_sample(SAMPLE_TOP, 1'b0);
    send_sample(SAMPLE_BOT, 1'b0);
    send_sample(SAMPLE_BOT, 1'b0);
  endtask

  // high-pass difference saturates on its own; history keeps the low-pass value
  task automatic test_high_pass();
    program_filter(MODE_HIGH_PASS, COEF_BOT, '0, '0, '0, '0);
    send_sample(SAMPLE_TOP, 1'b1);
    send_sample(SAMPLE_BOT, 1'b0);
    program_filter(MODE_HIGH_PASS, COEF_HALF, COEF_HALF, '0, -COEF_HALF, '0);
    send_sample(16'sd1000, 1'b0);
    send_sample(-16'sd1000, 1'b0);
    send_sample(SAMPLE_TOP, 1'b0);
  endtask

  // bypass and the unused mode pass samples, stream start still clears history
  task automatic test_bypass();
    program_filter(MODE_BYPASS, COEF_ONE, COEF_HALF, COEF_HALF, '0, '0);
    send_sample(16'sd20000, 1'b0);
    send_sample(-16'sd20000, 1'b1);
    program_filter(MODE_UNUSED, COEF_ONE, COEF_HALF, COEF_HALF, '0, '0);
    send_sample(16'sd12345, 1'b0);
    // mode change alone keeps the history
    program_filter(MODE_LOW_PASS, COEF_ONE, COEF_HALF, COEF_HALF, '0, '0);
    send_sample(16'sd100, 1'b0);
  endtask

  // writes above the register list change nothing
  task automatic test_spare_index();
    drain_stream();
    write_reg(REG_SPARE_SIX, 18'($urandom));
    write_reg(REG_SPARE_SEVEN, 18'($urandom));
    cfg_we_i <= 1'b0;
    send_sample(16'sd300, 1'b0);
    send_sample(-16'sd300, 1'b0);
  endtask

  // random settings, streams of random samples
  task automatic test_random_streams();
    int         phase;
    int         left;
    int         len;
    int         i;
    logic [1:0] mode;
    logic       first;
    for (phase = 0; phase < 20; phase++) begin
      idle_en = (phase % 4) != 3;
      case ($urandom_range(0, 5))
        0, 1:    mode = MODE_LOW_PASS;
        2, 3:    mode = MODE_HIGH_PASS;
        4:       mode = MODE_BYPASS;
        default: mode = MODE_UNUSED;
      endcase
      if (phase == 0)
        program_filter(MODE_LOW_PASS, COEF_TOP, COEF_TOP, COEF_TOP, COEF_TOP, COEF_TOP);
      else if (phase == 1)
        program_filter(MODE_HIGH_PASS, COEF_BOT, COEF_BOT, COEF_BOT, COEF_BOT, COEF_BOT);
      else
        program_filter(mode, pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                       pick_coef());
      left = 100;
      while (left > 0) begin
        len = $urandom_range(1, 40);
        for (i = 0; i < len && left > 0; i++) begin
          // mostly clean streams, a few stray stream starts
          first = (i == 0) ? 1'b1 : ($urandom_range(0, 19) == 0);
          send_sample(pick_sample(), first);
          left--;
        end
      end
    end
    idle_en = 1'b1;
  endtask

  initial begin
    rst_ni                 <= 1'b0;
    cfg_we_i               <= 1'b0;
    cfg_addr_i             <= '0;
    cfg_data_i             <= '0;
    in_bus.valid           <= 1'b0;
    in_bus.sample_in       <= '0;
    in_bus.first_of_stream <= 1'b0;
    err_count   = 0;
    cycle_count = 0;
    idle_en     = 1'b1;
    filt_mode   = MODE_LOW_PASS;
    coef_in     = '0;
    coef_x1     = '0;
    coef_x2     = '0;
    coef_y1     = '0;
    coef_y2     = '0;
    hist_x1     = '0;
    hist_x2     = '0;
    hist_y1     = '0;
    hist_y2     = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_low_pass_gain();
    test_high_pass();
    test_bypass();
    test_spare_index();
    test_random_streams();
    drain_stream();

    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
